// ===== src/sgss_pkg.sv =====
// Package for the scatter-gather slice splitter.
// Holds the item types, command and result codes, and bus widths.
// No dependencies; every other file uses it.
package sgss_pkg;

  localparam int WordW    = 64;
  localparam int InDataW  = 4 * WordW;
  localparam int OutDataW = 3 * WordW;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic {
    CMD_BUFFER = 1'b0,
    CMD_EXTENT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SLICE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_NOBUF = 2'd2,
    KIND_ORDER = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t  command;
    word_t buffer_address;
    word_t buffer_size;
    word_t file_offset;
    word_t extent_span;
  } in_item_t;

  typedef struct packed {
    kind_t result_kind;
    word_t slice_address;
    word_t slice_offset;
    word_t slice_length;
    logic  last;
  } out_item_t;

endpackage

// ===== src/scatter_gather_slice_splitter_top.sv =====
// Scatter-gather slice splitter, top level.
// Merges buffer and extent descriptors into transfer slices.
// Input side: s_axis_* carries one descriptor item per handshake; tuser
// says whether it is a memory buffer (0) or a file extent (1).
// Output side: m_axis_* carries slice, done, buffers-exhausted and
// order-error results; tuser holds the result kind and tlast marks the
// result that ends a request.
// Two register stages: the input handshake loads the input register, and
// the result register then loads from it through the slice compare/subtract
// step once the result register is free. Throughput is one item per cycle
// while the receiver takes results, set by the single state update of the step stage.
// An expected extent of nonzero span that arrives with no buffer bytes left produces no result.
// Reset clears both stages and returns the request state to its start
// (extent expected first). When the receiver stalls, the result register
// holds its item and the input register, if empty, can still take one more item;
// after that s_axis_tready falls until the result is taken.
// Depends on sgss_pkg, sgss_in_stage and sgss_step.
module scatter_gather_slice_splitter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // buffer_address, buffer_size, file_offset, extent_span (lowest first)
  input  logic [sgss_pkg::InDataW-1:0]  s_axis_tdata,
  // command
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slice_address, slice_offset, slice_length (lowest first)
  output logic [sgss_pkg::OutDataW-1:0] m_axis_tdata,
  // result_kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int W = sgss_pkg::WordW;

  sgss_pkg::in_item_t  in_item, staged_item;
  sgss_pkg::out_item_t res_item;
  logic                staged_valid, staged_ready;

  always_comb begin
    in_item.command        = sgss_pkg::cmd_t'(s_axis_tuser[0]);
    in_item.buffer_address = s_axis_tdata[0*W +: W];
    in_item.buffer_size    = s_axis_tdata[1*W +: W];
    in_item.file_offset    = s_axis_tdata[2*W +: W];
    in_item.extent_span    = s_axis_tdata[3*W +: W];
  end

  sgss_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (staged_valid),
    .out_ready (staged_ready),
    .out_item  (staged_item)
  );

  sgss_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (staged_valid),
    .in_ready  (staged_ready),
    .in_item   (staged_item),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_item  (res_item)
  );

  assign m_axis_tdata = {res_item.slice_length, res_item.slice_offset, res_item.slice_address};
  assign m_axis_tuser = res_item.result_kind;
  assign m_axis_tlast = res_item.last;

endmodule

// ===== src/sgss_in_stage.sv =====
// Input register stage of the slice splitter.
// Captures one descriptor item a cycle while empty or while the next stage takes its held item; depends on sgss_pkg.
module sgss_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sgss_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sgss_pkg::in_item_t out_item
);

  logic               held;
  sgss_pkg::in_item_t item;

  // load when empty or when the held item moves on this cycle
  assign in_ready  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== src/sgss_step.sv =====
// Splitter step: request state, slice arithmetic and the result register.
// One compare and a set of parallel adds/subtracts per item; depends on sgss_pkg.
module sgss_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgss_pkg::in_item_t  in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output sgss_pkg::out_item_t res_item
);

  sgss_pkg::word_t cur_address, cur_address_next;
  sgss_pkg::word_t buf_remaining, buf_remaining_next;
  sgss_pkg::word_t cur_offset, cur_offset_next;
  sgss_pkg::word_t span_remaining, span_remaining_next;
  logic            wants_extent, wants_extent_next;

  logic                res_held;
  sgss_pkg::out_item_t result, result_next;
  logic                emit;
  logic                take;

  // slice operands, chosen by which side the item refills
  sgss_pkg::word_t op_addr, op_buf, op_off, op_span;
  sgss_pkg::word_t len, buf_less_span, span_less_buf;
  logic            buf_smaller;

  assign in_ready  = !res_held || res_ready;
  assign take      = in_valid && in_ready;
  assign res_valid = res_held;
  assign res_item  = result;

  always_comb begin
    if (in_item.command == sgss_pkg::CMD_EXTENT) begin
      op_addr = cur_address;
      op_buf  = buf_remaining;
      op_off  = in_item.file_offset;
      op_span = in_item.extent_span;
    end else begin
      op_addr = in_item.buffer_address;
      op_buf  = in_item.buffer_size;
      op_off  = cur_offset;
      op_span = span_remaining;
    end
    buf_smaller   = op_buf < op_span;
    len           = buf_smaller ? op_buf : op_span;
    buf_less_span = op_buf - op_span;
    span_less_buf = op_span - op_buf;
  end

  always_comb begin
    cur_address_next    = cur_address;
    buf_remaining_next  = buf_remaining;
    cur_offset_next     = cur_offset;
    span_remaining_next = span_remaining;
    wants_extent_next   = wants_extent;
    emit                = 1'b1;
    result_next         = '{result_kind:   sgss_pkg::KIND_SLICE,
                            slice_address: op_addr,
                            slice_offset:  op_off,
                            slice_length:  len,
                            last:          1'b0};

    if ((in_item.command == sgss_pkg::CMD_EXTENT) != wants_extent) begin
      // wrong kind: flag and leave the request as it is
      result_next = '{result_kind: sgss_pkg::KIND_ORDER, default: '0};
    end else if (in_item.command == sgss_pkg::CMD_EXTENT && in_item.extent_span == '0) begin
      cur_address_next    = '0;
      buf_remaining_next  = '0;
      cur_offset_next     = '0;
      span_remaining_next = '0;
      wants_extent_next   = 1'b1;
      result_next         = '{result_kind: sgss_pkg::KIND_DONE, last: 1'b1, default: '0};
    end else if (in_item.command == sgss_pkg::CMD_BUFFER && in_item.buffer_size == '0) begin
      cur_address_next    = '0;
      buf_remaining_next  = '0;
      cur_offset_next     = '0;
      span_remaining_next = '0;
      wants_extent_next   = 1'b1;
      result_next         = '{result_kind: sgss_pkg::KIND_NOBUF, last: 1'b1, default: '0};
    end else if (in_item.command == sgss_pkg::CMD_EXTENT && buf_remaining == '0) begin
      // extent arrives with no buffer bytes left: hold it and ask for a buffer
      cur_offset_next     = in_item.file_offset;
      span_remaining_next = in_item.extent_span;
      wants_extent_next   = 1'b0;
      emit                = 1'b0;
    end else begin
      cur_address_next    = op_addr + len;
      cur_offset_next     = op_off + len;
      buf_remaining_next  = buf_smaller ? '0 : buf_less_span;
      span_remaining_next = buf_smaller ? span_less_buf : '0;
      wants_extent_next   = !buf_smaller;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_address    <= '0;
      buf_remaining  <= '0;
      cur_offset     <= '0;
      span_remaining <= '0;
      wants_extent   <= 1'b1;
    end else if (take) begin
      cur_address    <= cur_address_next;
      buf_remaining  <= buf_remaining_next;
      cur_offset     <= cur_offset_next;
      span_remaining <= span_remaining_next;
      wants_extent   <= wants_extent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_held <= 1'b0;
    end else if (in_ready) begin
      res_held <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= result_next;
    end
  end

endmodule
